// ----- design/tile_map_quad_generator_core_assert.svh -----
// ----------------------------------------------------------------------------
// Tile map quad generator: assertion macros
// Concurrent assertion shorthands sampled on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TILE_MAP_QUAD_GENERATOR_CORE_ASSERT_SVH
`define TILE_MAP_QUAD_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define TMQG_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define TMQG_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- design/tmqg_pkg.sv -----
// ----------------------------------------------------------------------------
// Tile map quad generator: package
// Sizes, register indexes, corner tables, shared types and clamp functions.
// ----------------------------------------------------------------------------
package tmqg_pkg;

    localparam int MAX_MAP_DIM     = 1024;
    localparam int MAX_TILE_SIZE   = 256;
    localparam int MAX_TILESET_DIM = 256;
    localparam int VERTS_PER_TILE  = 6;

    localparam int MAP_DIM_W   = $clog2(MAX_MAP_DIM + 1);
    localparam int COUNT_W     = $clog2(MAX_MAP_DIM);
    localparam int TILE_SIZE_W = $clog2(MAX_TILE_SIZE + 1);
    localparam int TSET_DIM_W  = $clog2(MAX_TILESET_DIM + 1);
    localparam int CELL_W      = $clog2(MAX_TILESET_DIM);
    localparam int TOTAL_W     = $clog2(MAX_TILESET_DIM * MAX_TILESET_DIM + 1);
    localparam int LOCAL_W     = $clog2(MAX_TILESET_DIM * MAX_TILESET_DIM);
    localparam int DIV_COUNT_W = $clog2(LOCAL_W);
    localparam int GID_W       = 32;
    localparam int POS_W       = 19;
    localparam int TEX_W       = 17;
    localparam int CORNER_W    = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(VERTS_PER_TILE - 1);

    // corner offsets, bit k for corner k; unused codes read as zero
    localparam logic [2**CORNER_W-1:0] CORNER_X = 8'b0001_1010;
    localparam logic [2**CORNER_W-1:0] CORNER_Y = 8'b0011_0100;

    localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TILE_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TILE_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TILESET_COLS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TILESET_ROWS = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_GID    = 3'd6;

    typedef struct packed {
        logic [MAP_DIM_W-1:0]   map_w;
        logic [MAP_DIM_W-1:0]   map_h;
        logic [TILE_SIZE_W-1:0] tile_w;
        logic [TILE_SIZE_W-1:0] tile_h;
        logic [TSET_DIM_W-1:0]  set_cols;
        logic [TSET_DIM_W-1:0]  set_rows;
        logic [GID_W-1:0]       first_gid;
        logic [TOTAL_W-1:0]     total;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] col;
        logic [COUNT_W-1:0] row;
        logic [CELL_W-1:0]  cell_x;
        logic [CELL_W-1:0]  cell_y;
    } tile_job_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [MAP_DIM_W-1:0] clamp_map(input logic [MAP_DIM_W-1:0] v);
        logic [MAP_DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = MAP_DIM_W'(1);
        else if (v > MAP_DIM_W'(MAX_MAP_DIM))
            r = MAP_DIM_W'(MAX_MAP_DIM);
        return r;
    endfunction

    function automatic logic [TILE_SIZE_W-1:0] clamp_tile(input logic [TILE_SIZE_W-1:0] v);
        logic [TILE_SIZE_W-1:0] r;
        r = v;
        if (v == '0)
            r = TILE_SIZE_W'(1);
        else if (v > TILE_SIZE_W'(MAX_TILE_SIZE))
            r = TILE_SIZE_W'(MAX_TILE_SIZE);
        return r;
    endfunction

    function automatic logic [TSET_DIM_W-1:0] clamp_tset(input logic [TSET_DIM_W-1:0] v);
        logic [TSET_DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = TSET_DIM_W'(1);
        else if (v > TSET_DIM_W'(MAX_TILESET_DIM))
            r = TSET_DIM_W'(MAX_TILESET_DIM);
        return r;
    endfunction

endpackage

// ----- design/tmqg_if.sv -----
// ----------------------------------------------------------------------------
// Tile map quad generator: channel interfaces
// Tile id input, vertex output and register write channels.
// ----------------------------------------------------------------------------
interface tmqg_tile_if
    import tmqg_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [GID_W-1:0] gid;

    modport source (output valid, output gid, input ready);
    modport sink   (input valid, input gid, output ready);
endinterface

interface tmqg_vertex_if
    import tmqg_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [TEX_W-1:0]    tex_u;
    logic [TEX_W-1:0]    tex_v;
    logic [CORNER_W-1:0] corner;
    logic                last_of_tile;

    modport source (output valid, output pos_x, output pos_y, output tex_u, output tex_v,
                    output corner, output last_of_tile, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input tex_u, input tex_v,
                    input corner, input last_of_tile, output ready);
endinterface

interface tmqg_cfg_if
    import tmqg_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/tmqg_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Tile map quad generator: configuration registers
// Clamps size registers on write and keeps the tileset tile count.
// ----------------------------------------------------------------------------
module tmqg_cfg_regs
    import tmqg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tmqg_cfg_if.sink   cfg,
    output cfg_t       regs
);

    logic [MAP_DIM_W-1:0]   map_w_reg;
    logic [MAP_DIM_W-1:0]   map_h_reg;
    logic [TILE_SIZE_W-1:0] tile_w_reg;
    logic [TILE_SIZE_W-1:0] tile_h_reg;
    logic [TSET_DIM_W-1:0]  set_cols_reg;
    logic [TSET_DIM_W-1:0]  set_rows_reg;
    logic [GID_W-1:0]       first_gid_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     total_next;
    logic                   wr;

    assign cfg.ready  = 1'b1;
    assign wr         = cfg.valid && cfg.ready;
    assign total_next = TOTAL_W'(set_cols_reg) * TOTAL_W'(set_rows_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_w_reg     <= MAP_DIM_W'(1);
            map_h_reg     <= MAP_DIM_W'(1);
            tile_w_reg    <= TILE_SIZE_W'(16);
            tile_h_reg    <= TILE_SIZE_W'(16);
            set_cols_reg  <= TSET_DIM_W'(1);
            set_rows_reg  <= TSET_DIM_W'(1);
            first_gid_reg <= GID_W'(1);
            total_reg     <= TOTAL_W'(1);
        end
        else
        begin
            total_reg <= total_next;
            if (wr)
            begin
                unique case (cfg.index)
                    REG_MAP_WIDTH:    map_w_reg    <= clamp_map(cfg.data[MAP_DIM_W-1:0]);
                    REG_MAP_HEIGHT:   map_h_reg    <= clamp_map(cfg.data[MAP_DIM_W-1:0]);
                    REG_TILE_WIDTH:   tile_w_reg   <= clamp_tile(cfg.data[TILE_SIZE_W-1:0]);
                    REG_TILE_HEIGHT:  tile_h_reg   <= clamp_tile(cfg.data[TILE_SIZE_W-1:0]);
                    REG_TILESET_COLS: set_cols_reg <= clamp_tset(cfg.data[TSET_DIM_W-1:0]);
                    REG_TILESET_ROWS: set_rows_reg <= clamp_tset(cfg.data[TSET_DIM_W-1:0]);
                    REG_FIRST_GID:    first_gid_reg <= cfg.data[GID_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    assign regs = '{map_w: map_w_reg, map_h: map_h_reg, tile_w: tile_w_reg,
                    tile_h: tile_h_reg, set_cols: set_cols_reg, set_rows: set_rows_reg,
                    first_gid: first_gid_reg, total: total_reg};

endmodule

// ----- design/tmqg_divider.sv -----
// ----------------------------------------------------------------------------
// Tile map quad generator: serial divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tmqg_divider
    import tmqg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [LOCAL_W-1:0]    dividend,
    input  logic [TSET_DIM_W-1:0] divisor,
    output div_status_t           status,
    output logic [LOCAL_W-1:0]    quotient,
    output logic [TSET_DIM_W-1:0] remainder
);

    logic                   busy_reg;
    logic                   done_reg;
    logic [DIV_COUNT_W-1:0] count_reg;
    logic [LOCAL_W-1:0]     quo_reg;
    logic [LOCAL_W-1:0]     quo_next;
    logic [TSET_DIM_W-1:0]  rem_reg;
    logic [TSET_DIM_W-1:0]  rem_next;
    logic [TSET_DIM_W:0]    trial;
    logic [TSET_DIM_W:0]    diff;
    logic                   ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[LOCAL_W-1]};
        diff     = trial - {1'b0, divisor};
        ge       = trial >= {1'b0, divisor};
        rem_next = ge ? diff[TSET_DIM_W-1:0] : trial[TSET_DIM_W-1:0];
        quo_next = {quo_reg[LOCAL_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= DIV_COUNT_W'(LOCAL_W - 1);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - DIV_COUNT_W'(1);
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign status    = '{busy: busy_reg, done: done_reg};
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- design/tmqg_vertex_gen.sv -----
// ----------------------------------------------------------------------------
// Tile map quad generator: vertex generator
// Forms base products once per tile, then steps through the six corners.
// ----------------------------------------------------------------------------
module tmqg_vertex_gen
    import tmqg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  tile_job_t              job,
    input  logic [TILE_SIZE_W-1:0] tile_w,
    input  logic [TILE_SIZE_W-1:0] tile_h,
    output logic                   busy,
    tmqg_vertex_if.source          vertex
);

    localparam logic [1:0] G_IDLE = 2'd0;
    localparam logic [1:0] G_BASE = 2'd1;
    localparam logic [1:0] G_LOAD = 2'd2;
    localparam logic [1:0] G_EMIT = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [CORNER_W-1:0] corner_reg;
    logic [CORNER_W-1:0] corner_next;
    logic                valid_reg;
    logic                valid_next;
    logic                load;

    tile_job_t           job_reg;
    logic [POS_W-1:0]    base_x_reg;
    logic [POS_W-1:0]    base_y_reg;
    logic [TEX_W-1:0]    base_u_reg;
    logic [TEX_W-1:0]    base_v_reg;
    logic [POS_W-1:0]    pos_x_reg;
    logic [POS_W-1:0]    pos_y_reg;
    logic [TEX_W-1:0]    tex_u_reg;
    logic [TEX_W-1:0]    tex_v_reg;
    logic [CORNER_W-1:0] out_corner_reg;
    logic                last_reg;
    logic                cx;
    logic                cy;

    assign cx = CORNER_X[corner_reg];
    assign cy = CORNER_Y[corner_reg];

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        valid_next  = valid_reg;
        load        = 1'b0;
        unique case (state_reg)
            G_IDLE:
            begin
                if (start)
                begin
                    state_next = G_BASE;
                end
            end
            G_BASE:
            begin
                corner_next = '0;
                state_next  = G_LOAD;
            end
            G_LOAD:
            begin
                load        = 1'b1;
                valid_next  = 1'b1;
                corner_next = corner_reg + CORNER_W'(1);
                state_next  = G_EMIT;
            end
            G_EMIT:
            begin
                if (vertex.ready)
                begin
                    if (last_reg)
                    begin
                        valid_next = 1'b0;
                        state_next = G_IDLE;
                    end
                    else
                    begin
                        load        = 1'b1;
                        corner_next = corner_reg + CORNER_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= G_IDLE;
            corner_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == G_IDLE))
        begin
            job_reg <= job;
        end
        if (state_reg == G_BASE)
        begin
            base_x_reg <= POS_W'(job_reg.col) * POS_W'(tile_w);
            base_y_reg <= POS_W'(job_reg.row) * POS_W'(tile_h);
            base_u_reg <= TEX_W'(job_reg.cell_x) * TEX_W'(tile_w);
            base_v_reg <= TEX_W'(job_reg.cell_y) * TEX_W'(tile_h);
        end
        if (load)
        begin
            pos_x_reg      <= base_x_reg + (cx ? POS_W'(tile_w) : POS_W'(0));
            pos_y_reg      <= base_y_reg + (cy ? POS_W'(tile_h) : POS_W'(0));
            tex_u_reg      <= base_u_reg + (cx ? TEX_W'(tile_w) : TEX_W'(0));
            tex_v_reg      <= base_v_reg + (cy ? TEX_W'(tile_h) : TEX_W'(0));
            out_corner_reg <= corner_reg;
            last_reg       <= (corner_reg == LAST_CORNER);
        end
    end

    assign busy                = (state_reg != G_IDLE);
    assign vertex.valid        = valid_reg;
    assign vertex.pos_x        = pos_x_reg;
    assign vertex.pos_y        = pos_y_reg;
    assign vertex.tex_u        = tex_u_reg;
    assign vertex.tex_v        = tex_v_reg;
    assign vertex.corner       = out_corner_reg;
    assign vertex.last_of_tile = last_reg;

endmodule

// ----- design/tile_map_quad_generator_core.sv -----
// ----------------------------------------------------------------------------
// Tile map quad generator core
// Turns raster-ordered tile ids into six textured vertices per drawn tile.
//
//   channel  role    carries
//   tile     sink    gid
//   vertex   source  pos_x, pos_y, tex_u, tex_v, corner, last_of_tile
//   cfg      sink    index, data (always ready)
//
// A skipped tile only passes through the check state; a drawn tile spends
// most of its time in the serial divider, which forms the quotient of the
// 16-bit local id one bit at a time.
// Reset is asynchronous, active low; no clearing pass is needed.
// A stalled vertex holds in the output register; tile.ready stays low until
// the sixth vertex transaction completes.
// ----------------------------------------------------------------------------
module tile_map_quad_generator_core
    import tmqg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tmqg_tile_if.sink     tile,
    tmqg_vertex_if.source vertex,
    tmqg_cfg_if.sink      cfg
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_DIVIDE = 2'd2;

    cfg_t                  regs;
    div_status_t           div_status;
    tile_job_t             job;
    logic [LOCAL_W-1:0]    quotient;
    logic [TSET_DIM_W-1:0] remainder;
    logic                  gen_busy;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [COUNT_W-1:0]    col_reg;
    logic [COUNT_W-1:0]    col_next;
    logic [COUNT_W-1:0]    row_reg;
    logic [COUNT_W-1:0]    row_next;
    logic [GID_W-1:0]      gid_reg;
    logic [COUNT_W-1:0]    item_col_reg;
    logic [COUNT_W-1:0]    item_row_reg;

    logic                  tile_acc;
    logic [MAP_DIM_W-1:0]  col_inc;
    logic [MAP_DIM_W-1:0]  row_inc;
    logic [GID_W:0]        diff;
    logic                  in_range;
    logic                  div_start;
    logic                  gen_start;

    tmqg_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    assign tile.ready = (state_reg == ST_IDLE) && !gen_busy;
    assign tile_acc   = tile.valid && tile.ready;

    always_comb
    begin
        col_inc  = {1'b0, col_reg} + MAP_DIM_W'(1);
        row_inc  = {1'b0, row_reg} + MAP_DIM_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (tile_acc)
        begin
            if (col_inc >= regs.map_w)
            begin
                col_next = '0;
                row_next = (row_inc >= regs.map_h) ? '0 : row_inc[COUNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[COUNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        diff     = {1'b0, gid_reg} - {1'b0, regs.first_gid};
        in_range = (gid_reg != '0) && !diff[GID_W] && (diff[GID_W-1:TOTAL_W] == '0)
                   && (diff[TOTAL_W-1:0] < regs.total);
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        gen_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tile_acc)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (in_range)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    gen_start  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tile_acc)
        begin
            gid_reg      <= tile.gid;
            item_col_reg <= col_reg;
            item_row_reg <= row_reg;
        end
    end

    tmqg_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (diff[LOCAL_W-1:0]),
        .divisor   (regs.set_cols),
        .status    (div_status),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign job = '{col: item_col_reg, row: item_row_reg,
                   cell_x: remainder[CELL_W-1:0], cell_y: quotient[CELL_W-1:0]};

    tmqg_vertex_gen u_vertex_gen (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gen_start),
        .job    (job),
        .tile_w (regs.tile_w),
        .tile_h (regs.tile_h),
        .busy   (gen_busy),
        .vertex (vertex)
    );

endmodule

// ----- design/tmqg_checker.sv -----
// ----------------------------------------------------------------------------
// Tile map quad generator: port checker
// Port-level checks on tile and vertex transactions, bound to the core.
// ----------------------------------------------------------------------------
`include "tile_map_quad_generator_core_assert.svh"

module tmqg_checker
    import tmqg_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                tile_valid,
    input logic                tile_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [POS_W-1:0]    out_pos_x,
    input logic [POS_W-1:0]    out_pos_y,
    input logic [TEX_W-1:0]    out_tex_u,
    input logic [TEX_W-1:0]    out_tex_v,
    input logic [CORNER_W-1:0] out_corner,
    input logic                out_last
);

    logic tile_acc;
    logic out_acc;

    assign tile_acc = tile_valid && tile_ready;
    assign out_acc  = out_valid && out_ready;

    `TMQG_ASSERT_NEXT(a_busy_after_tile, tile_acc, !tile_ready, "tile accepted while busy")
    `TMQG_ASSERT_NOW(a_no_tile_while_out, out_valid, !tile_ready, "tile ready during vertices")
    `TMQG_ASSERT_NEXT(a_quad_unbroken, out_acc && !out_last, out_valid, "gap inside a quad")
    `TMQG_ASSERT_NEXT(a_corner_step, out_acc && !out_last, out_corner == ($past(out_corner) + CORNER_W'(1)), "corner out of order")
    `TMQG_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_tex_u) && $stable(out_tex_v) && $stable(out_corner), "stalled vertex changed")

endmodule

bind tile_map_quad_generator_core tmqg_checker u_tmqg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tile_valid (tile.valid),
    .tile_ready (tile.ready),
    .out_valid  (vertex.valid),
    .out_ready  (vertex.ready),
    .out_pos_x  (vertex.pos_x),
    .out_pos_y  (vertex.pos_y),
    .out_tex_u  (vertex.tex_u),
    .out_tex_v  (vertex.tex_v),
    .out_corner (vertex.corner),
    .out_last   (vertex.last_of_tile)
);
